/* src/dro_pkg.sv */
package dro_pkg;

   localparam int ACC_W    = 48;
   localparam int HEAD_W   = 25;
   localparam int DIST_W   = 16;
   localparam int TURN_W   = 24;
   localparam int PHASE_W  = 32;
   localparam int CORDIC_W = 34;
   localparam int CSR_W    = 32;
   localparam int CSR_AW   = 3;

   localparam int FRAC_BITS_DEF = 16;
   localparam int TRIG_BITS_DEF = 16;

   localparam int HEAD_MAX = 16777215;

   localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   localparam logic [TURN_W-1:0]  TWO_PI_RST    = TURN_W'(65536);
   localparam logic [PHASE_W-1:0] PHASE_PER_RST = PHASE_W'(65536);

   localparam logic signed [CORDIC_W-1:0] GAIN_Q30 = CORDIC_W'(652032874);

   localparam int ATAN_N  = 32;
   localparam int ATAN_IW = $clog2(ATAN_N);

   localparam logic [PHASE_W-1:0] ATAN_TAB [ATAN_N] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
      32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
   };

   localparam logic REQ_UPDATE = 1'b0;
   localparam logic REQ_LOAD   = 1'b1;

   localparam logic REG_TWO_PI    = 1'b0;
   localparam logic REG_PHASE_PER = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WRAP,
      ST_START,
      ST_WAIT,
      ST_ACCUM,
      ST_FINISH
   } state_type;

endpackage

/* src/dro_phase_mul.sv */
module dro_phase_mul (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [dro_pkg::HEAD_W-1:0]  heading,
   input  logic        [dro_pkg::PHASE_W-1:0] scale,
   output logic        [dro_pkg::PHASE_W-1:0] phase,
   output logic                               done
);
   import dro_pkg::*;

   localparam int CNT_W = $clog2(HEAD_W);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [HEAD_W-1:0]   mplr_ff, mplr_in;
   logic [PHASE_W-1:0]  mcnd_ff, mcnd_in;
   logic [PHASE_W-1:0]  acc_ff, acc_in;
   logic [PHASE_W-1:0]  addend;
   logic                last;

   assign last   = (cnt_ff == CNT_W'(HEAD_W - 1));
   assign addend = mplr_ff[0] ? mcnd_ff : '0;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      mplr_in = mplr_ff;
      mcnd_in = mcnd_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         mplr_in = heading;
         mcnd_in = scale;
         acc_in  = '0;
      end else if (busy_ff) begin
         // sign bit of the heading carries negative weight
         acc_in  = last ? acc_ff - addend : acc_ff + addend;
         mplr_in = mplr_ff >> 1;
         mcnd_in = mcnd_ff << 1;
         cnt_in  = cnt_ff + CNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      mplr_ff <= mplr_in;
      mcnd_ff <= mcnd_in;
      acc_ff  <= acc_in;
   end

   assign phase = acc_ff;
   assign done  = done_ff;

endmodule

/* src/dro_cordic.sv */
module dro_cordic #(
   parameter int TRIG_BITS = dro_pkg::TRIG_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic        [dro_pkg::PHASE_W-1:0] phase,
   output logic signed [TRIG_BITS+1:0]        cos_val,
   output logic signed [TRIG_BITS+1:0]        sin_val,
   output logic                               done
);
   import dro_pkg::*;

   localparam int TW = TRIG_BITS + 2;
   localparam int RS = 30 - TRIG_BITS;
   localparam logic signed [CORDIC_W-1:0] HALF = CORDIC_W'(64'd1 << (RS - 1));

   logic                       busy_ff, busy_in;
   logic                       rnd_ff, rnd_in;
   logic                       done_ff, done_in;
   logic                       flip_ff, flip_in;
   logic [ATAN_IW-1:0]         idx_ff, idx_in;
   logic signed [CORDIC_W-1:0] x_ff, x_in;
   logic signed [CORDIC_W-1:0] y_ff, y_in;
   logic signed [CORDIC_W-1:0] z_ff, z_in;
   logic signed [TW-1:0]       cos_ff, cos_in;
   logic signed [TW-1:0]       sin_ff, sin_in;

   logic                       last;
   logic                       quad_flip;
   logic [PHASE_W-1:0]         ph_rot;
   logic signed [CORDIC_W-1:0] xs, ys, ang;
   logic signed [CORDIC_W-1:0] xr, yr;
   logic signed [TW-1:0]       cos_rnd, sin_rnd;

   assign last      = (idx_ff == ATAN_IW'(TRIG_BITS - 1));
   assign quad_flip = phase[PHASE_W-1] ^ phase[PHASE_W-2];
   assign ph_rot    = {phase[PHASE_W-1] ^ quad_flip, phase[PHASE_W-2:0]};
   assign xs        = x_ff >>> idx_ff;
   assign ys        = y_ff >>> idx_ff;
   assign ang       = CORDIC_W'(ATAN_TAB[idx_ff]);
   assign xr        = (x_ff + HALF) >>> RS;
   assign yr        = (y_ff + HALF) >>> RS;
   assign cos_rnd   = xr[TW-1:0];
   assign sin_rnd   = yr[TW-1:0];

   always_comb begin
      busy_in = busy_ff;
      rnd_in  = rnd_ff;
      done_in = 1'b0;
      flip_in = flip_ff;
      idx_in  = idx_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      cos_in  = cos_ff;
      sin_in  = sin_ff;
      if (start) begin
         busy_in = 1'b1;
         rnd_in  = 1'b0;
         flip_in = quad_flip;
         idx_in  = '0;
         x_in    = GAIN_Q30;
         y_in    = '0;
         z_in    = CORDIC_W'(signed'(ph_rot));
      end else if (busy_ff) begin
         if (z_ff[CORDIC_W-1]) begin
            x_in = x_ff + ys;
            y_in = y_ff - xs;
            z_in = z_ff + ang;
         end else begin
            x_in = x_ff - ys;
            y_in = y_ff + xs;
            z_in = z_ff - ang;
         end
         idx_in = idx_ff + ATAN_IW'(1);
         if (last) begin
            busy_in = 1'b0;
            rnd_in  = 1'b1;
         end
      end else if (rnd_ff) begin
         cos_in  = flip_ff ? -cos_rnd : cos_rnd;
         sin_in  = flip_ff ? -sin_rnd : sin_rnd;
         rnd_in  = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rnd_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         rnd_ff  <= rnd_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      flip_ff <= flip_in;
      idx_ff  <= idx_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
   end

   assign cos_val = cos_ff;
   assign sin_val = sin_ff;
   assign done    = done_ff;

endmodule

/* src/dro_step_mul.sv */
module dro_step_mul #(
   parameter int FRAC_BITS = dro_pkg::FRAC_BITS_DEF,
   parameter int TRIG_BITS = dro_pkg::TRIG_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [dro_pkg::DIST_W-1:0] distance,
   input  logic signed [TRIG_BITS+1:0]       trig,
   output logic signed [dro_pkg::ACC_W:0]    step,
   output logic                              done
);
   import dro_pkg::*;

   localparam int TW    = TRIG_BITS + 2;
   localparam int PW    = DIST_W + TW;
   localparam int CNT_W = $clog2(DIST_W);

   logic                    busy_ff, busy_in;
   logic                    fin_ff, fin_in;
   logic                    done_ff, done_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [DIST_W-1:0]       mplr_ff, mplr_in;
   logic signed [PW-1:0]    mcnd_ff, mcnd_in;
   logic signed [PW-1:0]    acc_ff, acc_in;
   logic signed [ACC_W:0]   step_ff, step_in;
   logic signed [PW-1:0]    addend;
   logic signed [ACC_W:0]   scaled;
   logic                    last;

   assign last   = (cnt_ff == CNT_W'(DIST_W - 1));
   assign addend = mplr_ff[0] ? mcnd_ff : '0;

   if (TRIG_BITS > FRAC_BITS) begin : g_round
      localparam int SH = TRIG_BITS - FRAC_BITS;
      localparam logic signed [PW:0] HALF = (PW + 1)'(64'd1 << (SH - 1));
      logic signed [PW:0] rnd;
      assign rnd    = (PW + 1)'(acc_ff) + HALF;
      assign scaled = (ACC_W + 1)'(rnd >>> SH);
   end else begin : g_shift
      assign scaled = (ACC_W + 1)'(acc_ff) <<< (FRAC_BITS - TRIG_BITS);
   end

   always_comb begin
      busy_in = busy_ff;
      fin_in  = fin_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      mplr_in = mplr_ff;
      mcnd_in = mcnd_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      if (start) begin
         busy_in = 1'b1;
         fin_in  = 1'b0;
         cnt_in  = '0;
         mplr_in = distance;
         mcnd_in = PW'(trig);
         acc_in  = '0;
      end else if (busy_ff) begin
         // sign bit of the distance carries negative weight
         acc_in  = last ? acc_ff - addend : acc_ff + addend;
         mplr_in = mplr_ff >> 1;
         mcnd_in = mcnd_ff <<< 1;
         cnt_in  = cnt_ff + CNT_W'(1);
         if (last) begin
            busy_in = 1'b0;
            fin_in  = 1'b1;
         end
      end else if (fin_ff) begin
         step_in = scaled;
         fin_in  = 1'b0;
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      mplr_ff <= mplr_in;
      mcnd_ff <= mcnd_in;
      acc_ff  <= acc_in;
      step_ff <= step_in;
   end

   assign step = step_ff;
   assign done = done_ff;

endmodule

/* src/dead_reckoning_odometry_core.sv */
// Dead-reckoning odometry core.
// Input channel (req_valid/req_ready): one item per transfer. An update item
// adds the orientation delta to the heading, wraps it by one turn, takes
// cosine and sine of the heading and advances X and Y by distance times each,
// saturating at the 48-bit range. A load item sets X, Y and heading.
// Result channel (rsp_valid/rsp_ready): one result per item, the position and
// heading after that item; the outputs are the committed position registers.
// Steps: an update runs the bit-serial heading-to-phase multiply, then the
// iterative CORDIC with a rounding step, then the bit-serial distance multiply
// for X and Y in parallel. A load skips these steps and goes to the commit.
// Throughput: one item at a time; req_ready is high only while the core idles.
// A new item is taken while the previous result still waits; its result is
// held inside until the result channel is free, so a stalled receiver stalls
// the core only once a second result is ready.
// Reset (synchronous) clears position and heading, empties the result channel
// and restores the registers: two_pi_pulses = 65536, phase_per_pulse = 65536.
// The user must write the APB-style register port only while the core is idle; the core has no check.
module dead_reckoning_odometry_core #(
   parameter int FRAC_BITS = dro_pkg::FRAC_BITS_DEF,
   parameter int TRIG_BITS = dro_pkg::TRIG_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   input  logic signed [dro_pkg::DIST_W-1:0] req_distance_delta,
   input  logic signed [dro_pkg::DIST_W-1:0] req_orientation_delta,
   input  logic signed [dro_pkg::ACC_W-1:0]  req_load_x,
   input  logic signed [dro_pkg::ACC_W-1:0]  req_load_y,
   input  logic signed [dro_pkg::HEAD_W-1:0] req_load_heading,

   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [dro_pkg::ACC_W-1:0]  rsp_pos_x,
   output logic signed [dro_pkg::ACC_W-1:0]  rsp_pos_y,
   output logic signed [dro_pkg::HEAD_W-1:0] rsp_heading,

   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [dro_pkg::CSR_AW-1:0]        paddr,
   input  logic [dro_pkg::CSR_W-1:0]         pwdata,
   output logic [dro_pkg::CSR_W-1:0]         prdata,
   output logic                              pready
);
   import dro_pkg::*;

   localparam int TW = TRIG_BITS + 2;
   localparam int HX = HEAD_W + 2;

   function automatic logic signed [HEAD_W-1:0] sat_head(input logic signed [HX-1:0] v);
      logic signed [HX-1:0] lim;
      lim = HX'(HEAD_MAX);
      if (v > lim) begin
         return HEAD_W'(lim);
      end else if (v < -lim) begin
         return HEAD_W'(-lim);
      end
      return HEAD_W'(v);
   endfunction

   function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [ACC_W:0] v);
      if (v[ACC_W] != v[ACC_W-1]) begin
         return v[ACC_W] ? ACC_MIN : ACC_MAX;
      end
      return ACC_W'(v);
   endfunction

   state_type                 state_ff, state_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [TURN_W-1:0]         two_pi_ff, two_pi_in;
   logic [PHASE_W-1:0]        phase_per_ff, phase_per_in;
   logic signed [ACC_W-1:0]   x_acc_ff, x_acc_in;
   logic signed [ACC_W-1:0]   y_acc_ff, y_acc_in;
   logic signed [HEAD_W-1:0]  heading_acc_ff, heading_acc_in;

   logic signed [DIST_W-1:0]  dist_ff, dist_in;
   logic signed [HEAD_W:0]    hsum_ff, hsum_in;
   logic signed [HEAD_W-1:0]  hd_ff, hd_in;
   logic signed [ACC_W-1:0]   nxt_x_ff, nxt_x_in;
   logic signed [ACC_W-1:0]   nxt_y_ff, nxt_y_in;

   logic                      cfg_wr;
   logic                      ph_start;
   logic [PHASE_W-1:0]        phase;
   logic                      ph_done;
   logic signed [TW-1:0]      cos_val, sin_val;
   logic                      cor_done;
   logic signed [ACC_W:0]     step_x, step_y;
   logic                      stx_done, sty_done;

   logic signed [HX-1:0]      h_ext, t_ext, h_red;
   logic signed [ACC_W:0]     sum_x, sum_y;
   logic                      out_free;

   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite & pready;

   always_comb begin
      two_pi_in    = two_pi_ff;
      phase_per_in = phase_per_ff;
      if (cfg_wr) begin
         unique case (paddr[2])
            REG_TWO_PI:    two_pi_in    = pwdata[TURN_W-1:0];
            REG_PHASE_PER: phase_per_in = pwdata[PHASE_W-1:0];
            default:       two_pi_in    = two_pi_ff;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[2])
         REG_TWO_PI:    prdata = CSR_W'(two_pi_ff);
         REG_PHASE_PER: prdata = phase_per_ff;
         default:       prdata = '0;
      endcase
   end

   assign h_ext = HX'(hsum_ff);
   assign t_ext = HX'(two_pi_ff);
   assign h_red = (h_ext > t_ext)  ? h_ext - t_ext :
                  (h_ext < -t_ext) ? h_ext + t_ext : h_ext;

   assign sum_x    = (ACC_W + 1)'(x_acc_ff) + step_x;
   assign sum_y    = (ACC_W + 1)'(y_acc_ff) + step_y;
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in       = state_ff;
      rsp_valid_in   = rsp_valid_ff;
      x_acc_in       = x_acc_ff;
      y_acc_in       = y_acc_ff;
      heading_acc_in = heading_acc_ff;
      dist_in        = dist_ff;
      hsum_in        = hsum_ff;
      hd_in          = hd_ff;
      nxt_x_in       = nxt_x_ff;
      nxt_y_in       = nxt_y_ff;
      req_ready      = 1'b0;
      ph_start       = 1'b0;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_type == REQ_LOAD) begin
                  nxt_x_in = req_load_x;
                  nxt_y_in = req_load_y;
                  hd_in    = sat_head(HX'(req_load_heading));
                  state_in = ST_FINISH;
               end else begin
                  dist_in  = req_distance_delta;
                  hsum_in  = (HEAD_W + 1)'(heading_acc_ff)
                           + (HEAD_W + 1)'(req_orientation_delta);
                  state_in = ST_WRAP;
               end
            end
         end
         ST_WRAP: begin
            hd_in    = sat_head(h_red);
            state_in = ST_START;
         end
         ST_START: begin
            ph_start = 1'b1;
            state_in = ST_WAIT;
         end
         ST_WAIT: begin
            if (stx_done && sty_done) begin
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            nxt_x_in = sat_acc(sum_x);
            nxt_y_in = sat_acc(sum_y);
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // hold the result until the output register is free
            if (out_free) begin
               x_acc_in       = nxt_x_ff;
               y_acc_in       = nxt_y_ff;
               heading_acc_in = hd_ff;
               rsp_valid_in   = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         two_pi_ff      <= TWO_PI_RST;
         phase_per_ff   <= PHASE_PER_RST;
         x_acc_ff       <= '0;
         y_acc_ff       <= '0;
         heading_acc_ff <= '0;
      end else begin
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         two_pi_ff      <= two_pi_in;
         phase_per_ff   <= phase_per_in;
         x_acc_ff       <= x_acc_in;
         y_acc_ff       <= y_acc_in;
         heading_acc_ff <= heading_acc_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff  <= dist_in;
      hsum_ff  <= hsum_in;
      hd_ff    <= hd_in;
      nxt_x_ff <= nxt_x_in;
      nxt_y_ff <= nxt_y_in;
   end

   dro_phase_mul u_phase_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (ph_start),
      .heading (hd_ff),
      .scale   (phase_per_ff),
      .phase   (phase),
      .done    (ph_done)
   );

   dro_cordic #(
      .TRIG_BITS (TRIG_BITS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (ph_done),
      .phase   (phase),
      .cos_val (cos_val),
      .sin_val (sin_val),
      .done    (cor_done)
   );

   dro_step_mul #(
      .FRAC_BITS (FRAC_BITS),
      .TRIG_BITS (TRIG_BITS)
   ) u_step_x (
      .clock    (clock),
      .reset    (reset),
      .start    (cor_done),
      .distance (dist_ff),
      .trig     (cos_val),
      .step     (step_x),
      .done     (stx_done)
   );

   dro_step_mul #(
      .FRAC_BITS (FRAC_BITS),
      .TRIG_BITS (TRIG_BITS)
   ) u_step_y (
      .clock    (clock),
      .reset    (reset),
      .start    (cor_done),
      .distance (dist_ff),
      .trig     (sin_val),
      .step     (step_y),
      .done     (sty_done)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_pos_x   = x_acc_ff;
   assign rsp_pos_y   = y_acc_ff;
   assign rsp_heading = heading_acc_ff;

endmodule
